/* design/rau_pkg.sv */
package rau_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int MAG_W = 64;
	localparam int K_W = 6;
	localparam int CNT_W = 7;

	localparam logic [2:0] CMD_NORM = 3'd0;
	localparam logic [2:0] CMD_ADD  = 3'd1;
	localparam logic [2:0] CMD_SUB  = 3'd2;
	localparam logic [2:0] CMD_MUL  = 3'd3;
	localparam logic [2:0] CMD_DIV  = 3'd4;
	localparam logic [2:0] CMD_CMP  = 3'd5;

	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_DIV0 = 2'd1;
	localparam logic [1:0] ERR_OVF  = 2'd2;

	typedef struct packed {
		logic load;
		logic mul;
		logic comb;
		logic ginit;
		logic gstep;
		logic dinit;
		logic dstep;
		logic out;
	} rau_cmd_t;

	typedef struct packed {
		logic early;
		logic is_cmp;
		logic mul_last;
		logic gcd_done;
		logic div_done;
	} rau_stat_t;

endpackage

/* design/rau_ctrl.sv */
module rau_ctrl import rau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  rau_stat_t stat,
	output rau_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_COMB, S_GINIT, S_GCD, S_DINIT, S_DIV, S_OUT
	} state_t;

	state_t state_q;
	logic done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		cmd = '0;
		cmd.load  = start && (state_q == S_IDLE);
		cmd.mul   = (state_q == S_MUL) && !stat.early;
		cmd.comb  = (state_q == S_COMB);
		cmd.ginit = (state_q == S_GINIT);
		cmd.gstep = (state_q == S_GCD) && !stat.gcd_done;
		cmd.dinit = (state_q == S_DINIT);
		cmd.dstep = (state_q == S_DIV) && !stat.div_done;
		cmd.out   = (state_q == S_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_MUL;
				end
				S_MUL: begin
					if (stat.early) state_q <= S_OUT;
					else if (stat.mul_last) state_q <= S_COMB;
				end
				S_COMB: begin
					state_q <= stat.is_cmp ? S_OUT : S_GINIT;
				end
				S_GINIT: state_q <= S_GCD;
				S_GCD: begin
					if (stat.gcd_done) state_q <= S_DINIT;
				end
				S_DINIT: state_q <= S_DIV;
				S_DIV: begin
					if (stat.div_done) state_q <= S_OUT;
				end
				S_OUT: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* design/rau_datapath.sv */
module rau_datapath import rau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rau_cmd_t    cmd,
	output rau_stat_t   stat,
	input  logic [2:0]  command,
	input  logic [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic [31:0] b_num,
	input  logic [31:0] b_den,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic        is_less,
	output logic        is_equal,
	output logic        is_greater,
	output logic [1:0]  error_code
);

	localparam logic [MAG_W-1:0] LIM = MAG_W'(1) << (VALUE_WIDTH - 1);

	logic [2:0] cmd_q;
	logic [31:0] an_q, ad_q, bn_q, bd_q;
	logic sa_q, sb_q, bad_q;
	logic [1:0] err_q;
	logic [1:0] mi_q;
	logic [MAG_W-1:0] p_q, q_q, rd_q;
	logic [MAG_W-1:0] n_q, d_q;
	logic neg_q, lt_q, eq_q, gt_q;
	logic [MAG_W-1:0] x_q, y_q;
	logic [K_W-1:0] k_q;
	logic [MAG_W-1:0] g_q, nr_q, dr_q, nqo_q, dqo_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	logic [31:0] an_m, ad_m, bn_m, bd_m;
	assign an_m = mag32(a_num);
	assign ad_m = mag32(a_den);
	assign bn_m = mag32(b_num);
	assign bd_m = mag32(b_den);

	logic [31:0] mul_a, mul_b;
	logic [MAG_W-1:0] prod;
	always_comb begin
		case (mi_q)
			2'd0: begin
				mul_a = an_q;
				mul_b = (cmd_q == CMD_MUL) ? bn_q : ((cmd_q == CMD_NORM) ? 32'd1 : bd_q);
			end
			2'd1: begin
				mul_a = ad_q;
				mul_b = bn_q;
			end
			default: begin
				mul_a = ad_q;
				mul_b = (cmd_q == CMD_NORM) ? 32'd1 : bd_q;
			end
		endcase
		prod = MAG_W'(mul_a) * MAG_W'(mul_b);
	end

	logic sb2;
	logic [MAG_W-1:0] n_c;
	logic neg_c;
	always_comb begin
		sb2 = (cmd_q == CMD_SUB) ? ((q_q != '0) && !sb_q) : sb_q;
		if (cmd_q == CMD_NORM || cmd_q == CMD_MUL || cmd_q == CMD_DIV) begin
			n_c = p_q;
			neg_c = (cmd_q == CMD_NORM) ? sa_q : (sa_q ^ sb_q);
		end else if (sa_q == sb2) begin
			n_c = p_q + q_q;
			neg_c = sa_q;
		end else if (p_q >= q_q) begin
			n_c = p_q - q_q;
			neg_c = sa_q;
		end else begin
			n_c = q_q - p_q;
			neg_c = sb2;
		end
	end

	logic [MAG_W-1:0] nsh, dsh;
	assign nsh = {nr_q[MAG_W-2:0], nqo_q[MAG_W-1]};
	assign dsh = {dr_q[MAG_W-2:0], dqo_q[MAG_W-1]};

	logic ovf;
	assign ovf = (dqo_q > LIM - 1) || (nqo_q > LIM) || (!neg_q && nqo_q > LIM - 1);

	assign stat.early = bad_q || (err_q != ERR_OK);
	assign stat.is_cmp = (cmd_q == CMD_CMP);
	assign stat.mul_last = (mi_q == 2'd2);
	assign stat.gcd_done = (x_q == '0) || (y_q == '0);
	assign stat.div_done = (cnt_q == CNT_W'(MAG_W));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mi_q <= '0;
			cnt_q <= '0;
			res_num <= '0;
			res_den <= '0;
			is_less <= 1'b0;
			is_equal <= 1'b0;
			is_greater <= 1'b0;
			error_code <= ERR_OK;
		end else begin
			if (cmd.load) begin
				cmd_q <= command;
				an_q <= an_m;
				ad_q <= ad_m;
				bn_q <= bn_m;
				bd_q <= bd_m;
				sa_q <= (an_m != '0) && (a_num[31] ^ a_den[31]);
				sb_q <= (bn_m != '0) && (b_num[31] ^ b_den[31]);
				bad_q <= (command > CMD_CMP);
				err_q <= ((ad_m == '0) || (command != CMD_NORM && bd_m == '0) ||
					(command == CMD_DIV && bn_m == '0)) ? ERR_DIV0 : ERR_OK;
				mi_q <= '0;
			end
			if (cmd.mul) begin
				case (mi_q)
					2'd0: p_q <= prod;
					2'd1: q_q <= prod;
					default: rd_q <= prod;
				endcase
				mi_q <= mi_q + 2'd1;
			end
			if (cmd.comb) begin
				n_q <= n_c;
				neg_q <= neg_c;
				d_q <= (cmd_q == CMD_DIV) ? q_q : rd_q;
				if (sa_q != sb_q) begin
					lt_q <= sa_q;
					eq_q <= 1'b0;
					gt_q <= !sa_q;
				end else if (p_q == q_q) begin
					lt_q <= 1'b0;
					eq_q <= 1'b1;
					gt_q <= 1'b0;
				end else begin
					lt_q <= (p_q < q_q) != sa_q;
					eq_q <= 1'b0;
					gt_q <= (p_q < q_q) == sa_q;
				end
			end
			if (cmd.ginit) begin
				k_q <= '0;
				if (n_q == '0) begin
					neg_q <= 1'b0;
					d_q <= MAG_W'(1);
					x_q <= '0;
					y_q <= MAG_W'(1);
				end else begin
					x_q <= n_q;
					y_q <= d_q;
				end
			end
			if (cmd.gstep) begin
				if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					k_q <= k_q + K_W'(1);
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q >= y_q) begin
					x_q <= x_q - y_q;
				end else begin
					y_q <= y_q - x_q;
				end
			end
			if (cmd.dinit) begin
				g_q <= (x_q | y_q) << k_q;
				nr_q <= '0;
				dr_q <= '0;
				nqo_q <= n_q;
				dqo_q <= d_q;
				cnt_q <= '0;
			end
			if (cmd.dstep) begin
				if (nsh >= g_q) begin
					nr_q <= nsh - g_q;
					nqo_q <= {nqo_q[MAG_W-2:0], 1'b1};
				end else begin
					nr_q <= nsh;
					nqo_q <= {nqo_q[MAG_W-2:0], 1'b0};
				end
				if (dsh >= g_q) begin
					dr_q <= dsh - g_q;
					dqo_q <= {dqo_q[MAG_W-2:0], 1'b1};
				end else begin
					dr_q <= dsh;
					dqo_q <= {dqo_q[MAG_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.out) begin
				res_num <= '0;
				res_den <= '0;
				is_less <= 1'b0;
				is_equal <= 1'b0;
				is_greater <= 1'b0;
				error_code <= ERR_OK;
				if (bad_q) begin
					error_code <= ERR_OK;
				end else if (err_q != ERR_OK) begin
					error_code <= err_q;
				end else if (cmd_q == CMD_CMP) begin
					is_less <= lt_q;
					is_equal <= eq_q;
					is_greater <= gt_q;
				end else if (ovf) begin
					error_code <= ERR_OVF;
				end else begin
					res_num <= neg_q ? (32'd0 - nqo_q[31:0]) : nqo_q[31:0];
					res_den <= dqo_q[30:0];
				end
			end
		end
	end

endmodule

/* design/rational_arithmetic_unit_core.sv */
// Rational arithmetic unit: takes one command with two fractions when start is high and busy
// is low, and returns one reduced result marked by a one-cycle done strobe that cannot be
// stalled; sample the result ports in that cycle. An item goes through three products on the
// shared 32x32 multiplier, a binary gcd of one subtract or shift per cycle on 64-bit
// magnitudes, then two restoring dividers run side by side. Errors skip the products,
// the gcd and the dividers; compares skip the gcd and the dividers.
module rational_arithmetic_unit_core import rau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [2:0]  command,
	input  logic [31:0] a_num,
	input  logic [31:0] a_den,
	input  logic [31:0] b_num,
	input  logic [31:0] b_den,
	output logic [31:0] res_num,
	output logic [30:0] res_den,
	output logic        is_less,
	output logic        is_equal,
	output logic        is_greater,
	output logic [1:0]  error_code
);

	rau_cmd_t cmd;
	rau_stat_t stat;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.cmd(cmd), .busy(busy), .done(done)
	);

	rau_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.command(command), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.res_num(res_num), .res_den(res_den), .is_less(is_less), .is_equal(is_equal),
		.is_greater(is_greater), .error_code(error_code)
	);

endmodule
